// ===== design/relative_distance_unit_top_macros.svh =====
// Assertion macros for the relative distance unit.
// Included by relative_distance_unit_top; expects clock and reset in scope.
`ifndef RELATIVE_DISTANCE_UNIT_TOP_MACROS_SVH
`define RELATIVE_DISTANCE_UNIT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RDU_ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("relative distance unit: same-cycle check failed");
`define RDU_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("relative distance unit: next-cycle check failed");
`else
`define RDU_ASSERT_IMPLIES(name, ante, cons)
`define RDU_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== design/rdu_pkg.sv =====
// Shared types and constants of the relative distance unit.
// No dependencies; used by rdu_prep, rdu_cell and relative_distance_unit_top.
`default_nettype none

package rdu_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int FRACTION_BITS = 16;
   localparam int OUT_FRAC      = 30;
   localparam int DIST_W        = 32;
   // two integer quotient bits plus the fraction bits
   localparam int QUO_STEPS     = OUT_FRAC + 2;

   localparam logic [OPERAND_WIDTH-1:0] SIGN_BIT = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
   localparam logic [OPERAND_WIDTH-1:0] ONE_IN   = OPERAND_WIDTH'(1) << FRACTION_BITS;
   localparam logic [OPERAND_WIDTH-1:0] TWO_IN   = OPERAND_WIDTH'(2) << FRACTION_BITS;
   localparam logic [DIST_W-1:0]        TWO_OUT  = DIST_W'(2) << OUT_FRAC;

   typedef struct packed {
      logic signed [OPERAND_WIDTH-1:0] value_a;
      logic signed [OPERAND_WIDTH-1:0] value_b;
      logic                            a_defined;
      logic                            b_defined;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              undefined_fault;
   } rsp_type;

   // Data handed from one divider cell to the next.
   typedef struct packed {
      logic [OPERAND_WIDTH:0]   rem;
      logic [OPERAND_WIDTH-1:0] divisor;
      logic                     next_bit;
      logic [DIST_W-1:0]        quo;
      logic                     use_div;
      logic                     fault;
   } div_stage_type;

endpackage

`default_nettype wire

// ===== design/rdu_prep.sv =====
// Front end of the relative distance unit: difference, magnitudes, case selection.
// Two registered stages; depends on rdu_pkg.
`default_nettype none

module rdu_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  rdu_pkg::req_type      up_data,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output rdu_pkg::div_stage_type dn_data
);
   import rdu_pkg::*;

   typedef struct packed {
      logic [OPERAND_WIDTH-1:0] diff;
      logic [OPERAND_WIDTH-1:0] mag_a;
      logic [OPERAND_WIDTH-1:0] mag_b;
      logic                     fault;
      logic                     equal;
      logic                     has_zero;
      logic                     opposite;
   } front_type;

   localparam int SCALE_W = OPERAND_WIDTH + OUT_FRAC - FRACTION_BITS;

   logic                     a_valid_ff, a_valid_in, a_ready;
   front_type                a_ff, a_in;
   logic                     b_valid_ff, b_valid_in;
   div_stage_type            b_ff, b_in;

   logic [OPERAND_WIDTH-1:0] raw_a, raw_b, bias_a, bias_b, max_mag;
   logic [SCALE_W-1:0]       scaled;
   logic [DIST_W-1:0]        sat_diff;
   logic                     small_diff;

   assign a_ready  = !b_valid_ff || dn_ready;
   assign up_ready = !a_valid_ff || a_ready;

   // Stage A: biased difference and magnitudes
   always_comb begin
      raw_a  = up_data.value_a;
      raw_b  = up_data.value_b;
      bias_a = raw_a ^ SIGN_BIT;
      bias_b = raw_b ^ SIGN_BIT;
      a_in.diff     = (bias_a > bias_b) ? (bias_a - bias_b) : (bias_b - bias_a);
      a_in.mag_a    = raw_a[OPERAND_WIDTH-1] ? ((~raw_a) + 1'b1) : raw_a;
      a_in.mag_b    = raw_b[OPERAND_WIDTH-1] ? ((~raw_b) + 1'b1) : raw_b;
      a_in.fault    = !(up_data.a_defined && up_data.b_defined);
      a_in.equal    = (raw_a == raw_b);
      a_in.has_zero = (raw_a == '0) || (raw_b == '0);
      a_in.opposite = raw_a[OPERAND_WIDTH-1] != raw_b[OPERAND_WIDTH-1];
      a_valid_in    = up_ready ? up_valid : a_valid_ff;
   end

   // Stage B: pick the divisor or a direct result
   always_comb begin
      max_mag    = (a_ff.mag_a < a_ff.mag_b) ? a_ff.mag_b : a_ff.mag_a;
      small_diff = a_ff.diff < ONE_IN;
      scaled     = {a_ff.diff, {(OUT_FRAC-FRACTION_BITS){1'b0}}};
      sat_diff   = (a_ff.diff > TWO_IN) ? TWO_OUT : scaled[DIST_W-1:0];

      b_in.rem      = {2'b00, a_ff.diff[OPERAND_WIDTH-1:1]};
      b_in.next_bit = a_ff.diff[0];
      b_in.divisor  = max_mag;
      b_in.fault    = a_ff.fault;
      b_in.use_div  = !a_ff.fault && !a_ff.equal && !a_ff.has_zero &&
                      !(a_ff.opposite && small_diff);
      if (a_ff.fault || a_ff.equal || b_in.use_div) begin
         b_in.quo = '0;
      end else begin
         b_in.quo = sat_diff;
      end
      b_valid_in = a_ready ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      if (up_valid && up_ready) begin
         a_ff <= a_in;
      end
      if (a_valid_ff && a_ready) begin
         b_ff <= b_in;
      end
   end

   assign dn_valid = b_valid_ff;
   assign dn_data  = b_ff;

endmodule

`default_nettype wire

// ===== design/rdu_cell.sv =====
// One restoring-division cell: compare, subtract, emit one quotient bit.
// Holds one request in flight; depends on rdu_pkg.
`default_nettype none

module rdu_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  rdu_pkg::div_stage_type up_data,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output rdu_pkg::div_stage_type dn_data
);
   import rdu_pkg::*;

   logic                     valid_ff, valid_in;
   div_stage_type            data_ff, data_in;
   logic                     fits;
   logic [OPERAND_WIDTH:0]   sub;
   logic [OPERAND_WIDTH-1:0] part;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      fits    = up_data.rem >= {1'b0, up_data.divisor};
      sub     = up_data.rem - {1'b0, up_data.divisor};
      part    = fits ? sub[OPERAND_WIDTH-1:0] : up_data.rem[OPERAND_WIDTH-1:0];
      data_in = up_data;
      // direct results pass through untouched
      if (up_data.use_div) begin
         data_in.rem      = {part, up_data.next_bit};
         data_in.next_bit = 1'b0;
         data_in.quo      = {up_data.quo[DIST_W-2:0], fits};
      end
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ===== design/relative_distance_unit_top.sv =====
// Pipeline: 2 front-end stages followed by 32 divider cells.
// Throughput: one request per cycle while the result side does not stall; each divider cell resolves one quotient bit.
// Every stage holds its own request, so bubbles close up while the result side stalls.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
// Depends on rdu_pkg, rdu_prep, rdu_cell and relative_distance_unit_top_macros.svh.
`default_nettype none
`include "relative_distance_unit_top_macros.svh"

module relative_distance_unit_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rdu_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rdu_pkg::rsp_type rsp_payload
);
   import rdu_pkg::*;

   logic                   stage_valid [0:QUO_STEPS];
   logic                   stage_ready [0:QUO_STEPS];
   div_stage_type          stage_data  [0:QUO_STEPS];
   logic [OPERAND_WIDTH:0] cell_bound;

   rdu_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req_payload),
      .dn_valid (stage_valid[0]),
      .dn_ready (stage_ready[0]),
      .dn_data  (stage_data[0])
   );

   for (genvar k = 0; k < QUO_STEPS; k++) begin : g_cell
      rdu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[k]),
         .up_ready (stage_ready[k]),
         .up_data  (stage_data[k]),
         .dn_valid (stage_valid[k+1]),
         .dn_ready (stage_ready[k+1]),
         .dn_data  (stage_data[k+1])
      );
   end

   // the quotient never exceeds 2.0 since |a-b| <= 2*max(|a|,|b|)
   assign stage_ready[QUO_STEPS]     = rsp_ready;
   assign rsp_valid                  = stage_valid[QUO_STEPS];
   assign rsp_payload.distance       = stage_data[QUO_STEPS].quo;
   assign rsp_payload.undefined_fault = stage_data[QUO_STEPS].fault;

   assign cell_bound = {stage_data[1].divisor, 1'b0};

   `RDU_ASSERT_IMPLIES(a_fault_zero, rsp_valid && rsp_payload.undefined_fault, rsp_payload.distance == '0)
   `RDU_ASSERT_IMPLIES(a_dist_range, rsp_valid, rsp_payload.distance <= TWO_OUT)
   `RDU_ASSERT_IMPLIES(a_stall_full, !req_ready, rsp_valid && !rsp_ready)
   `RDU_ASSERT_IMPLIES(a_rem_bound, stage_valid[1] && stage_data[1].use_div, stage_data[1].rem < cell_bound)
   `RDU_ASSERT_NEXT(a_bypass_flow, stage_valid[0] && stage_ready[0] && !stage_data[0].use_div, stage_valid[1] && !stage_data[1].use_div)

endmodule

`default_nettype wire
